@@ rtl/core/skit_pkg.sv @@
package skit_pkg;

	localparam int KEY_W    = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 8;
	localparam int TOTAL_W  = 9;

	// opcodes
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]         opcode;
		logic signed [KEY_W-1:0] key;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [TOTAL_W-1:0]  entry_total;
	} rsp_word_t;

endpackage

@@ rtl/core/sorted_key_index_table.sv @@
// Sorted key index table: keys stored by slot, plus an index of slots in
// ascending key order.
// Request channel (req_valid/req_ready/req): one word carries an opcode
// (search, insert, delete) and a signed 32-bit key. req_ready is high only
// while the sequencer is idle; one word is worked on at a time.
// Response channel (rsp_valid/rsp_ready/rsp): one word per request with
// status, slot and the entry total after the operation.
// Steps per word, with n entries before the operation and at most
// L = ceil(log2 n) + 1 probes:
//   search : L probes, each reads index, then key, then compares
//   insert : search, key write, m entries moved up in the index, slot put
//   delete : search, index sweep over n-1 positions, keys above slot moved down
//   empty-table search or delete, or unused opcode: straight to finish.
// Each of the two memories has a single read port, shared by the probe
// loop and the move sweeps.
// The finished word sits in an output register; the next request is taken
// while it waits. If the receiver stalls and a second result is ready, the
// sequencer holds in its finish state until the output register frees.
// Reset clears the entry count and the handshake state; memory contents are
// left as they are and are never read above the entry count.
module sorted_key_index_table #(
	parameter int CAPACITY = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  skit_pkg::req_word_t   req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output skit_pkg::rsp_word_t   rsp
);
	import skit_pkg::*;

	localparam int IW = $clog2(CAPACITY);     // slot / index width
	localparam int CW = $clog2(CAPACITY + 1); // count width

	typedef enum logic [13:0] {
		IDLE       = 14'b00000000000001,
		SRCH_IDX   = 14'b00000000000010,
		SRCH_KEY   = 14'b00000000000100,
		SRCH_CMP   = 14'b00000000001000,
		INS_KEY    = 14'b00000000010000,
		INS_RD     = 14'b00000000100000,
		INS_WR     = 14'b00000001000000,
		INS_PUT    = 14'b00000010000000,
		DEL_SRT_RD = 14'b00000100000000,
		DEL_SRT_WR = 14'b00001000000000,
		DEL_KEY_RD = 14'b00010000000000,
		DEL_KEY_WR = 14'b00100000000000,
		DEL_END    = 14'b01000000000000,
		FINISH     = 14'b10000000000000
	} state_t;

	state_t state_q;

	// memories: key by slot, slot by sorted position
	logic signed [KEY_W-1:0] key_mem [CAPACITY];
	logic [IW-1:0]           srt_mem [CAPACITY];

	logic                    key_re, key_we, srt_re, srt_we;
	logic [IW-1:0]           key_raddr, key_waddr, srt_raddr, srt_waddr;
	logic signed [KEY_W-1:0] key_wdata, key_rd_q;
	logic [IW-1:0]           srt_wdata, srt_rd_q;

	// working registers
	logic [CW-1:0]           cnt_q, idx_q, p_q;
	logic [IW-1:0]           lo_q, hi_q, pos_q, slot_q;
	logic                    final_q;
	logic [OP_W-1:0]         op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [STATUS_W-1:0]     status_q;
	logic                    rsp_valid_q;
	rsp_word_t               rsp_q;

	logic [IW:0]   mid_sum;
	logic [IW-1:0] mid, lo_nx, hi_nx, adj;
	logic [CW-1:0] cnt_m1, idx_m1, idx_p1, src;
	logic          full, found;
	logic [31:0]   slot_ext, cnt_ext;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IW:1];
	assign cnt_m1  = cnt_q - 1'b1;
	assign idx_m1  = idx_q - 1'b1;
	assign idx_p1  = idx_q + 1'b1;
	assign full    = (cnt_q == CW'(CAPACITY));
	assign found   = (key_rd_q == key_q);
	// index sweep on delete skips the removed position
	assign src     = (idx_q < CW'(lo_q)) ? idx_q : idx_p1;
	assign adj     = (srt_rd_q > pos_q) ? srt_rd_q - 1'b1 : srt_rd_q;

	// one probe step of the lower-bound search
	always_comb begin
		lo_nx = lo_q;
		hi_nx = hi_q;
		if (key_q <= key_rd_q) begin
			hi_nx = mid;
		end else begin
			lo_nx = mid + 1'b1;
		end
	end

	// memory port control
	always_comb begin
		key_re    = 1'b0;
		key_we    = 1'b0;
		srt_re    = 1'b0;
		srt_we    = 1'b0;
		key_raddr = srt_rd_q;
		key_waddr = idx_q[IW-1:0];
		key_wdata = key_rd_q;
		srt_raddr = final_q ? lo_q : mid;
		srt_waddr = idx_q[IW-1:0];
		srt_wdata = srt_rd_q;
		case (state_q)
			SRCH_IDX: begin
				srt_re = 1'b1;
			end
			SRCH_KEY: begin
				key_re = 1'b1;
			end
			INS_KEY: begin
				key_we    = 1'b1;
				key_waddr = cnt_q[IW-1:0];
				key_wdata = key_q;
			end
			INS_RD: begin
				srt_re    = 1'b1;
				srt_raddr = idx_m1[IW-1:0];
			end
			INS_WR: begin
				srt_we = 1'b1;
			end
			INS_PUT: begin
				srt_we    = 1'b1;
				srt_waddr = p_q[IW-1:0];
				srt_wdata = cnt_q[IW-1:0];
			end
			DEL_SRT_RD: begin
				srt_re    = 1'b1;
				srt_raddr = src[IW-1:0];
			end
			DEL_SRT_WR: begin
				srt_we    = 1'b1;
				srt_wdata = adj;
			end
			DEL_KEY_RD: begin
				key_re    = 1'b1;
				key_raddr = idx_p1[IW-1:0];
			end
			DEL_KEY_WR: begin
				key_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		if (key_re) begin
			key_rd_q <= key_mem[key_raddr];
		end
		if (srt_we) begin
			srt_mem[srt_waddr] <= srt_wdata;
		end
		if (srt_re) begin
			srt_rd_q <= srt_mem[srt_raddr];
		end
	end

	assign req_ready = (state_q == IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			idx_q       <= '0;
			p_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			pos_q       <= '0;
			slot_q      <= '0;
			final_q     <= 1'b0;
			op_q        <= '0;
			key_q       <= '0;
			status_q    <= ST_MISS;
		end else begin
			// the finish state reloads the output register itself
			if (rsp_valid_q && rsp_ready && state_q != FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_valid) begin
						op_q     <= req.opcode;
						key_q    <= req.key;
						lo_q     <= '0;
						hi_q     <= cnt_m1[IW-1:0];
						final_q  <= (cnt_q == CW'(1));
						status_q <= ST_MISS;
						slot_q   <= '0;
						case (req.opcode)
							OP_SEARCH, OP_DELETE: begin
								state_q <= (cnt_q == '0) ? FINISH : SRCH_IDX;
							end
							OP_INSERT: begin
								if (cnt_q == '0) begin
									p_q     <= '0;
									idx_q   <= '0;
									state_q <= INS_KEY;
								end else begin
									state_q <= SRCH_IDX;
								end
							end
							default: begin
								state_q <= FINISH;
							end
						endcase
					end
				end
				SRCH_IDX: begin
					state_q <= SRCH_KEY;
				end
				SRCH_KEY: begin
					state_q <= SRCH_CMP;
				end
				SRCH_CMP: begin
					if (!final_q) begin
						lo_q    <= lo_nx;
						hi_q    <= hi_nx;
						final_q <= !(lo_nx < hi_nx);
						state_q <= SRCH_IDX;
					end else begin
						case (op_q)
							OP_SEARCH: begin
								state_q <= FINISH;
								if (found) begin
									status_q <= ST_OK;
									slot_q   <= srt_rd_q;
								end
							end
							OP_INSERT: begin
								if (found) begin
									status_q <= ST_DUP;
									state_q  <= FINISH;
								end else if (full) begin
									status_q <= ST_FULL;
									state_q  <= FINISH;
								end else begin
									// new key goes before lo, or after all
									p_q     <= (key_q < key_rd_q) ? CW'(lo_q) : cnt_q;
									idx_q   <= cnt_q;
									state_q <= INS_KEY;
								end
							end
							OP_DELETE: begin
								if (found) begin
									pos_q   <= srt_rd_q;
									idx_q   <= '0;
									state_q <= (cnt_q > CW'(1)) ? DEL_SRT_RD : DEL_END;
								end else begin
									state_q <= FINISH;
								end
							end
							default: begin
								state_q <= FINISH;
							end
						endcase
					end
				end
				INS_KEY: begin
					state_q <= (idx_q > p_q) ? INS_RD : INS_PUT;
				end
				INS_RD: begin
					state_q <= INS_WR;
				end
				INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= (idx_m1 > p_q) ? INS_RD : INS_PUT;
				end
				INS_PUT: begin
					cnt_q    <= cnt_q + 1'b1;
					status_q <= ST_OK;
					slot_q   <= cnt_q[IW-1:0];
					state_q  <= FINISH;
				end
				DEL_SRT_RD: begin
					state_q <= DEL_SRT_WR;
				end
				DEL_SRT_WR: begin
					if (idx_p1 == cnt_m1) begin
						// index done; shift keys above the removed slot
						idx_q   <= CW'(pos_q);
						state_q <= (CW'(pos_q) == cnt_m1) ? DEL_END : DEL_KEY_RD;
					end else begin
						idx_q   <= idx_p1;
						state_q <= DEL_SRT_RD;
					end
				end
				DEL_KEY_RD: begin
					state_q <= DEL_KEY_WR;
				end
				DEL_KEY_WR: begin
					idx_q   <= idx_p1;
					state_q <= (idx_p1 == cnt_m1) ? DEL_END : DEL_KEY_RD;
				end
				DEL_END: begin
					cnt_q    <= cnt_m1;
					status_q <= ST_OK;
					slot_q   <= pos_q;
					state_q  <= FINISH;
				end
				FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.status      <= status_q;
						rsp_q.slot        <= slot_ext[SLOT_W-1:0];
						rsp_q.entry_total <= cnt_ext[TOTAL_W-1:0];
						state_q           <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign slot_ext  = 32'(slot_q);
	assign cnt_ext   = 32'(cnt_q);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(state_q == INS_PUT) || $past(state_q == DEL_END))
		else $error("entry count changed outside insert or delete commit");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.slot == '0)
		else $error("nonzero slot with failing status");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		srt_we |-> (CW'(srt_waddr) < cnt_q + 1'b1) && (32'(srt_waddr) < CAPACITY))
		else $error("index write beyond live entries");

endmodule

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import skit_pkg::*;

	localparam int CAPACITY = 256;

	// Slowest word is a delete from a full table: nine probes, then two
	// sweeps of up to 255 moves each.
	localparam int SLOWEST_WORD   = 1100;
	localparam int LONG_HOLD      = 500;
	localparam int WATCHDOG_LIMIT = 8 * (SLOWEST_WORD + LONG_HOLD);

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

	// Opcode 3 is not defined by the package; the block must treat it as a miss.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// ------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the table and predicts each answer
	// at the moment a request word is accepted.
	// ------------------------------------------------------------------
	class table_checker;
		logic signed [KEY_W-1:0] key_at [CAPACITY];  // key held by each slot
		logic [SLOT_W-1:0]       order  [CAPACITY];  // slots by ascending key
		int                      fill;
		rsp_word_t               due_answers [$];
		int                      errors;

		function new();
			fill   = 0;
			errors = 0;
			foreach (key_at[i]) key_at[i] = '0;
			foreach (order[i]) order[i] = '0;
		endfunction

		// lower-bound binary search over the ordered slots
		function bit find_slot(input logic signed [KEY_W-1:0] k,
				output logic [SLOT_W-1:0] slot);
			int lo, hi, mid;
			slot = '0;
			if (fill == 0)
				return 0;
			lo = 0;
			hi = fill - 1;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (k <= key_at[order[mid]])
					hi = mid;
				else
					lo = mid + 1;
			end
			if (key_at[order[lo]] == k) begin
				slot = order[lo];
				return 1;
			end
			return 0;
		endfunction

		function void take_request(req_word_t w);
			rsp_word_t         ans;
			logic [SLOT_W-1:0] hit, s, t;
			bit                found;
			int                n, wr, i, j;
			ans.status = ST_MISS;
			ans.slot   = '0;
			found = find_slot(w.key, hit);
			case (w.opcode)
				OP_SEARCH: begin
					if (found) begin
						ans.status = ST_OK;
						ans.slot   = hit;
					end
				end
				OP_INSERT: begin
					if (found)
						ans.status = ST_DUP;
					else if (fill >= CAPACITY)
						ans.status = ST_FULL;
					else begin
						n = fill;
						key_at[n] = w.key;
						order[n]  = SLOT_W'(n);
						fill      = n + 1;
						// one downward bubble pass puts the new slot in place
						for (j = n; j >= 1; j--) begin
							if (key_at[order[j]] < key_at[order[j-1]]) begin
								t          = order[j];
								order[j]   = order[j-1];
								order[j-1] = t;
							end
						end
						ans.status = ST_OK;
						ans.slot   = SLOT_W'(n);
					end
				end
				OP_DELETE: begin
					if (found) begin
						n  = fill;
						wr = 0;
						// drop the slot from the order and renumber higher slots
						for (i = 0; i < n; i++) begin
							s = order[i];
							if (s != hit) begin
								order[wr] = (s > hit) ? s - 1'b1 : s;
								wr++;
							end
						end
						for (i = int'(hit); i + 1 < n; i++)
							key_at[i] = key_at[i+1];
						fill       = n - 1;
						ans.status = ST_OK;
						ans.slot   = hit;
					end
				end
				default: ;
			endcase
			ans.entry_total = TOTAL_W'(fill);
			due_answers.insert(due_answers.size(), ans);
		endfunction

		function void match_answer(rsp_word_t got);
			rsp_word_t want;
			if (due_answers.size() == 0) begin
				$display("%0t: extra response: expected none, got %0d/%0d/%0d",
					$time, got.status, got.slot, got.entry_total);
				errors++;
				return;
			end
			want = due_answers.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$display("%0t: slot mismatch: expected %0d, got %0d",
					$time, want.slot, got.slot);
				errors++;
			end
			if (got.entry_total !== want.entry_total) begin
				$display("%0t: entry_total mismatch: expected %0d, got %0d",
					$time, want.entry_total, got.entry_total);
				errors++;
			end
		endfunction

		function int pending();
			return due_answers.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT and its signals; every input has a known value from time zero.
	// ------------------------------------------------------------------
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	sorted_key_index_table #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	table_checker book;
	int           rsp_count  = 0;
	int           idle_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Monitor: both channels sampled at the edge, so the values seen are the
	// ones present just before it. Responses are checked before the request
	// of the same edge is noted, since they always belong to older words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				book.match_answer(rsp);
				rsp_count <= rsp_count + 1;
			end
			if (req_valid && req_ready)
				book.take_request(req);
		end
	end

	// Watchdog: too many cycles without any word moving ends the run.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: ready follows a duty cycle redrawn at each phase of random
	// length. Once, after 150 responses, it holds off for a long stretch so
	// the output register and the sequencer both fill and req_ready drops.
	initial begin : receiver
		int  duty, phase_left;
		bit  held;
		duty       = 100;
		phase_left = 0;
		held       = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && rsp_count >= 150) begin
				held = 1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (phase_left == 0) begin
					case ($urandom_range(0, 3))
						0: duty = 100;
						1: duty = 80;
						2: duty = 50;
						default: duty = 15;
					endcase
					phase_left = $urandom_range(10, 80);
				end
				phase_left--;
				rsp_ready <= ($urandom_range(0, 99) < duty);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Keys the table holds once every issued word has been applied; used to
	// steer stimulus toward hits and to tell when the table is full or empty.
	logic signed [KEY_W-1:0] present_keys [$];
	logic signed [KEY_W-1:0] key_pool [$];
	int                      burst_left = 0;

	// Offer one word; returns at the edge where it is accepted. Between
	// bursts valid drops before the next word is offered.
	task automatic issue(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k);
		req_word_t w;
		int        idx [$];
		idx = present_keys.find_index with (item == k);
		if (op == OP_INSERT && idx.size() == 0 && present_keys.size() < CAPACITY)
			present_keys.insert(present_keys.size(), k);
		else if (op == OP_DELETE && idx.size() > 0)
			present_keys.delete(idx[0]);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 12);
		end
		burst_left--;
		w.opcode = op;
		w.key    = k;
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// Stop offering and wait until every answer has arrived. The first edge
	// lets the monitor note the word accepted just before.
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (book.pending() > 0) @(posedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] any_present();
		if (present_keys.size() == 0)
			return $urandom;
		return present_keys[$urandom_range(0, present_keys.size() - 1)];
	endfunction

	function automatic logic signed [KEY_W-1:0] pool_key();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// hit, or near miss just above or below a held key (random key if none is held)
	function automatic logic signed [KEY_W-1:0] probe_key();
		case ($urandom_range(0, 3))
			0, 1: return any_present();
			2: return any_present() + 1;
			default: return any_present() - 1;
		endcase
	endfunction

	// any of the four opcodes, for noise words
	function automatic logic [OP_W-1:0] OP_OP_any();
		return OP_W'($urandom_range(0, 3));
	endfunction

	initial begin : stimulus
		int r, i;
		book = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: empty table, extremes, dup, renumbering on delete ---
		issue(OP_SEARCH, 32'sd0);           // empty table search
		issue(OP_DELETE, KEY_MAX);          // empty table delete
		issue(OP_UNUSED, 32'h5555_5555);    // unused opcode on empty table
		issue(OP_INSERT, 32'sd0);
		issue(OP_INSERT, KEY_MIN);
		issue(OP_INSERT, KEY_MAX);
		issue(OP_INSERT, -32'sd1);
		issue(OP_INSERT, 32'sd1);
		issue(OP_INSERT, 32'sd0);           // duplicate
		issue(OP_SEARCH, KEY_MIN);
		issue(OP_SEARCH, KEY_MAX);
		issue(OP_SEARCH, 32'sd0);
		issue(OP_SEARCH, 32'sd2);           // miss between keys
		issue(OP_SEARCH, 32'h5555_5555);
		issue(OP_DELETE, -32'sd1);          // middle slot, higher slots move down
		issue(OP_SEARCH, 32'sd1);
		issue(OP_DELETE, KEY_MIN);
		issue(OP_UNUSED, 32'hAAAA_AAAA);    // unused opcode, table not empty
		issue(OP_DELETE, KEY_MAX);
		issue(OP_DELETE, 32'sd5);           // delete miss
		issue(OP_INSERT, KEY_MAX - 1);
		issue(OP_SEARCH, 32'hAAAA_AAAA);
		issue(OP_SEARCH, KEY_MAX - 1);

		// --- random, small table: keys drawn from a small pool ---
		key_pool = '{KEY_MIN, KEY_MAX, 32'sd0, -32'sd1, 32'sd1, KEY_MIN + 1, KEY_MAX - 1};
		repeat (13) key_pool.insert(key_pool.size(), $urandom);
		for (i = 0; i < 250; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				issue(OP_INSERT, pool_key());
			else if (r < 65)
				issue(OP_DELETE, ($urandom_range(0, 9) < 7) ? any_present() : pool_key());
			else if (r < 90)
				issue(OP_SEARCH, ($urandom_range(0, 1) == 0) ? probe_key() : pool_key());
			else if (r < 95)
				issue(OP_UNUSED, $urandom);
			else
				issue(OP_OP_any(), $urandom);
		end

		// sender pauses until the table is quiet
		drain();

		// --- fill to capacity with random keys ---
		while (present_keys.size() < CAPACITY) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				issue(OP_INSERT, $urandom);
			else if (r < 88)
				issue(OP_INSERT, any_present());
			else
				issue(OP_SEARCH, probe_key());
		end

		// --- full table: full, duplicate before full, search, miss ---
		repeat (3) issue(OP_INSERT, $urandom);
		repeat (2) issue(OP_INSERT, any_present());
		issue(OP_SEARCH, KEY_MIN);
		issue(OP_SEARCH, KEY_MAX);
		issue(OP_SEARCH, any_present());
		issue(OP_DELETE, $urandom);
		issue(OP_UNUSED, $urandom);

		// --- empty the table again in random order ---
		while (present_keys.size() > 0) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				issue(OP_DELETE, any_present());
			else if (r < 95)
				issue(OP_SEARCH, probe_key());
			else
				issue(OP_DELETE, $urandom);
		end
		issue(OP_SEARCH, KEY_MIN);
		issue(OP_DELETE, KEY_MAX);

		// --- end of run ---
		drain();
		repeat (SLOWEST_WORD) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
